@@ hdl/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants of the packed sprite pixel expander.
// ----------------------------------------------------------------------------
package spe_pkg;

    // Largest sprite side honored; larger register values are capped
    localparam int unsigned MAX_ICON_SIDE = 255;

    // Pixel formats
    localparam logic [1:0] FMT_TWO_BIT = 2'd2;
    localparam logic [1:0] FMT_NONE    = 2'd3;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_ICON_WIDTH   = 3'd2;
    localparam logic [2:0] REG_ICON_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd4;

    // Configuration as seen by the front end
    typedef struct packed {
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [7:0] icon_width;
        logic [7:0] icon_height;
        logic [1:0] pixel_format;
    } spe_cfg_t;

    // One classified byte: which of up to eight slots emit, and where
    typedef struct packed {
        logic [7:0] mask;   // slot j emits a pixel
        logic [7:0] black;  // color of slot j
        logic [8:0] x_base; // screen column of slot 0
        logic [8:0] y;      // screen row
    } spe_desc_t;

endpackage

@@ hdl/packed_sprite_pixel_expander.sv @@
// ----------------------------------------------------------------------------
// packed_sprite_pixel_expander
// Expands packed sprite bitmap bytes into placed black or white pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Program origin, size and format over the APB port while the block is
//   idle, then stream the sprite's bytes in row order on the s_ channel.
//   Each byte yields up to eight pixels on the m_ channel: column and row
//   on screen plus color; tlast marks the final pixel placed by a byte.
//   Transparent pixels and pixels in the row padding are dropped, and a
//   byte that places nothing produces no item at all.
//   The first pixel of a byte passes the queue entry, the back end's slot
//   registers and the output register before it shows on m_tvalid.
//   Throughput: one pixel per cycle out of the single output register
//   while m_tready is high; a byte that places nothing only uses the input.
//   A two-entry descriptor queue lets the input keep going while pixels
//   drain; when m_tready is low the output holds and, once the queue
//   fills, s_tready drops.
//   Reset clears the counters, the queue and the output, and loads the
//   registers with origin 0, width 1, height 1, one bit per pixel.
// ----------------------------------------------------------------------------
module packed_sprite_pixel_expander
    import spe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Bitmap bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    // Pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [8:0] pixel_x, [17:9] pixel_y, [18] pixel_black
    output logic        m_tlast    // last_of_byte
);

    spe_cfg_t   cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    logic       q_full;
    logic       push;
    spe_desc_t  push_desc;
    logic       pop;
    logic       head_valid;
    spe_desc_t  head_desc;

    logic [8:0] px;
    logic [8:0] py;
    logic       pb;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ORIGIN_X:     cfg_next.origin_x     = pwdata[7:0];
                REG_ORIGIN_Y:     cfg_next.origin_y     = pwdata[7:0];
                REG_ICON_WIDTH:   cfg_next.icon_width   = pwdata[7:0];
                REG_ICON_HEIGHT:  cfg_next.icon_height  = pwdata[7:0];
                REG_PIXEL_FORMAT: cfg_next.pixel_format = pwdata[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Return register contents
    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X:     prdata = {24'd0, cfg_reg.origin_x};
            REG_ORIGIN_Y:     prdata = {24'd0, cfg_reg.origin_y};
            REG_ICON_WIDTH:   prdata = {24'd0, cfg_reg.icon_width};
            REG_ICON_HEIGHT:  prdata = {24'd0, cfg_reg.icon_height};
            REG_PIXEL_FORMAT: prdata = {30'd0, cfg_reg.pixel_format};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= 8'd0;
            cfg_reg.origin_y     <= 8'd0;
            cfg_reg.icon_width   <= 8'd1;
            cfg_reg.icon_height  <= 8'd1;
            cfg_reg.pixel_format <= 2'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    spe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    spe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (px),
        .out_y      (py),
        .out_black  (pb),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'd0, pb, py, px};

endmodule

@@ hdl/spe_front.sv @@
// ----------------------------------------------------------------------------
// spe_front
// Accepts bitmap bytes, tracks row and byte-in-row position, and turns
// each byte into a descriptor of the pixels it places.
// ----------------------------------------------------------------------------
module spe_front
    import spe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  spe_cfg_t   cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       push,
    output spe_desc_t  push_desc
);

    localparam logic [9:0] MAX_SIDE = 10'(MAX_ICON_SIDE);

    logic [7:0] row_count_reg, row_count_next;
    logic [5:0] byte_in_row_reg, byte_in_row_next;

    logic [7:0] w;
    logic [7:0] h;
    logic [5:0] bytes8;
    logic [6:0] bpr;
    logic       two_bit;
    logic       accept;
    logic       in_row;
    logic [8:0] base_col;
    logic [8:0] col;
    logic [7:0] mask;
    logic [7:0] black;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Cap sizes and derive bytes per row
    always_comb
    begin
        w = ({2'b00, cfg.icon_width} > MAX_SIDE) ? MAX_SIDE[7:0] : cfg.icon_width;
        h = ({2'b00, cfg.icon_height} > MAX_SIDE) ? MAX_SIDE[7:0] : cfg.icon_height;
        two_bit = (cfg.pixel_format == FMT_TWO_BIT);
        bytes8  = 6'((9'({1'b0, w}) + 9'd7) >> 3);
        bpr     = two_bit ? {bytes8, 1'b0} : {1'b0, bytes8};
        in_row  = ({1'b0, byte_in_row_reg} < bpr);
        base_col = two_bit ? {1'b0, byte_in_row_reg, 2'b00}
                           : {byte_in_row_reg, 3'b000};
    end

    // Classify the slots of the byte
    always_comb
    begin
        mask  = '0;
        black = '0;
        col   = '0;
        for (int j = 0; j < 8; j++)
        begin
            col = base_col + 9'(j);
            if (two_bit)
            begin
                if (j < 4)
                begin
                    mask[j]  = !in_byte[7 - 2 * j] && (col < {1'b0, w});
                    black[j] = in_byte[6 - 2 * j];
                end
            end
            else
            begin
                mask[j]  = (col < {1'b0, w});
                black[j] = in_byte[7 - j];
            end
        end
        if (!in_row)
        begin
            mask = '0;
        end
    end

    // Build the descriptor
    always_comb
    begin
        push_desc.mask   = mask;
        push_desc.black  = black;
        push_desc.x_base = {1'b0, cfg.origin_x} + base_col;
        push_desc.y      = {1'b0, cfg.origin_y} + {1'b0, row_count_reg};
        push = accept && (cfg.pixel_format != FMT_NONE)
               && (row_count_reg < h) && (mask != '0);
    end

    // Advance the position counters
    always_comb
    begin
        row_count_next   = row_count_reg;
        byte_in_row_next = byte_in_row_reg;
        if (accept && (cfg.pixel_format != FMT_NONE))
        begin
            if (row_count_reg >= h)
            begin
                row_count_next   = '0;
                byte_in_row_next = '0;
            end
            else if ((7'({1'b0, byte_in_row_reg}) + 7'd1) >= bpr)
            begin
                byte_in_row_next = '0;
                if ((9'({1'b0, row_count_reg}) + 9'd1) >= {1'b0, h})
                begin
                    row_count_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + 8'd1;
                end
            end
            else
            begin
                byte_in_row_next = byte_in_row_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= '0;
            byte_in_row_reg <= '0;
        end
        else
        begin
            row_count_reg   <= row_count_next;
            byte_in_row_reg <= byte_in_row_next;
        end
    end

endmodule

@@ hdl/spe_queue.sv @@
// ----------------------------------------------------------------------------
// spe_queue
// Two-entry descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module spe_queue
    import spe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  spe_desc_t push_desc,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output spe_desc_t head_desc
);

    spe_desc_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Move pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

@@ hdl/spe_back.sv @@
// ----------------------------------------------------------------------------
// spe_back
// Walks the slots of one descriptor at a time and emits one pixel per
// cycle while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module spe_back
    import spe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  spe_desc_t head_desc,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [8:0] out_x,
    output logic [8:0] out_y,
    output logic      out_black,
    output logic      out_last
);

    logic [7:0] mask_reg, mask_next;
    logic [7:0] black_reg, black_next;
    logic [8:0] x_base_reg, x_base_next;
    logic [8:0] y_reg, y_next;

    logic       valid_reg, valid_next;
    logic [8:0] x_reg, x_next;
    logic [8:0] oy_reg, oy_next;
    logic       ob_reg, ob_next;
    logic       last_reg, last_next;

    logic       load_out;
    logic       emit;
    logic [2:0] sel;
    logic [7:0] rest;

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = oy_reg;
    assign out_black = ob_reg;
    assign out_last  = last_reg;

    // Pick the lowest pending slot
    always_comb
    begin
        sel = '0;
        for (int j = 7; j >= 0; j--)
        begin
            if (mask_reg[j])
            begin
                sel = 3'(j);
            end
        end
    end

    // Emit a pixel and refill from the queue
    always_comb
    begin
        load_out = !valid_reg || out_ready;
        emit     = load_out && (mask_reg != '0);
        rest     = mask_reg & ~(8'd1 << sel);

        x_next     = x_reg;
        oy_next    = oy_reg;
        ob_next    = ob_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        mask_next  = mask_reg;
        black_next = black_reg;
        x_base_next = x_base_reg;
        y_next     = y_reg;

        if (emit)
        begin
            x_next     = x_base_reg + {6'd0, sel};
            oy_next    = y_reg;
            ob_next    = black_reg[sel];
            last_next  = (rest == '0);
            valid_next = 1'b1;
            mask_next  = rest;
        end

        pop = head_valid && (mask_next == '0);
        if (pop)
        begin
            mask_next   = head_desc.mask;
            black_next  = head_desc.black;
            x_base_next = head_desc.x_base;
            y_next      = head_desc.y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mask_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        black_reg  <= black_next;
        x_base_reg <= x_base_next;
        y_reg      <= y_next;
        x_reg      <= x_next;
        oy_reg     <= oy_next;
        ob_reg     <= ob_next;
        last_reg   <= last_next;
    end

endmodule
